/* src/cpe_pkg.sv */
package cpe_pkg;

  // table size
  localparam int unsigned ENTRIES_DEF = 64;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CA_W     = 16;
  localparam int unsigned PROV_W   = 32;
  localparam int unsigned SVC_W    = 16;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REMOVE_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAN   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SKIP = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_AGE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN_INTERVAL = 2'd3;

  // register reset values
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST     = 20'd1000;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST     = 20'd60000;
  localparam logic [TIME_W-1:0]   STALE_AGE_RST      = 32'd600000;
  localparam logic [TIME_W-1:0]   CLEAN_INTERVAL_RST = 32'd300000;

  typedef struct packed {
    logic [CA_W-1:0]     ca;
    logic [PROV_W-1:0]   provider;
    logic [SVC_W-1:0]    service;
    logic [HALF_W-1:0]   word_high;
    logic [HALF_W-1:0]   word_low;
    logic [TIME_W-1:0]   last_change;
    logic [PERIOD_W-1:0] period;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* src/cpe_ram.sv */
module cpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/channel_period_estimator.sv */
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    kind, now_ms, ca_id, provider_id, service_id,
//                                                 word_high, word_low
// out       output     out_valid_o / out_ready_i  period_ms, found, status, removed_count
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index, cfg_data
//
// observe, query and cleanup walk every table slot through the single read port of the
// entry ram. a zero-key observe or an unused kind goes straight to the result state,
// and a cleanup that comes too soon after the last one goes there from its check
// state, so none of them scans the table
// one item at a time: in_ready_o is high only while the sequencer is idle
// the result sits in an output register; a stalled output holds the sequencer in its
// result state. reset clears valid bits and registers at once, no clearing pass
module channel_period_estimator #(
  parameter int unsigned ENTRIES = cpe_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cpe_pkg::KIND_W-1:0]    kind_i,
  input  logic [cpe_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [cpe_pkg::CA_W-1:0]      ca_id_i,
  input  logic [cpe_pkg::PROV_W-1:0]    provider_id_i,
  input  logic [cpe_pkg::SVC_W-1:0]     service_id_i,
  input  logic [cpe_pkg::HALF_W-1:0]    word_high_i,
  input  logic [cpe_pkg::HALF_W-1:0]    word_low_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cpe_pkg::PERIOD_W-1:0]  period_ms_o,
  output logic                          found_o,
  output logic [cpe_pkg::STATUS_W-1:0]  status_o,
  output logic [cpe_pkg::REMOVE_W-1:0]  removed_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cpe_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  import cpe_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1) + 1;
  localparam int unsigned SUM_W = PERIOD_W + 3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [PERIOD_W-1:0] min_period_q, max_period_q;
  logic [TIME_W-1:0]   stale_age_q, clean_interval_q, last_clean_q;

  // current item
  logic [KIND_W-1:0]   kind_q;
  logic [TIME_W-1:0]   now_q;
  logic [CA_W-1:0]     ca_q;
  logic [PROV_W-1:0]   prov_q;
  logic [SVC_W-1:0]    svc_q;
  logic [HALF_W-1:0]   wh_q, wl_q;

  // scan bookkeeping
  logic [ENTRIES-1:0]  valid_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;
  entry_t              hit_entry_q;
  logic                free_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [REMOVE_W-1:0] rem_q;
  logic [TIME_W-1:0]   delta_q;
  logic                chg_q;

  // result
  logic [PERIOD_W-1:0] res_period_q;
  logic                res_found_q;
  logic [STATUS_W-1:0] res_status_q;

  logic                out_valid_q;
  logic [PERIOD_W-1:0] out_period_q;
  logic                out_found_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [REMOVE_W-1:0] out_removed_q;

  // ram
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wentry, rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  // shared subtract and compare unit
  logic [TIME_W-1:0] sub_opnd, diff;
  logic              scan_done, key_match, out_free;
  logic              in_win;
  logic [SUM_W-1:0]  ewma_sum;
  logic [PERIOD_W-1:0] new_period;

  assign rd_entry = entry_t'(ram_rdata);
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign scan_done = (cnt_q == CNT_W'(ENTRIES)) && !rd_vld_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign key_match = (rd_entry.ca == ca_q) && (rd_entry.provider == prov_q) &&
                     (rd_entry.service == svc_q);

  always_comb begin
    case (state_q)
      S_CHECK: sub_opnd = last_clean_q;
      S_CALC:  sub_opnd = hit_entry_q.last_change;
      default: sub_opnd = rd_entry.last_change;
    endcase
  end

  assign diff = now_q - sub_opnd;

  // delta is below 2^20 whenever it is inside the window
  assign in_win = (delta_q >= TIME_W'(min_period_q)) && (delta_q <= TIME_W'(max_period_q));
  assign ewma_sum = {2'b00, hit_entry_q.period, 1'b0} + SUM_W'(hit_entry_q.period) +
                    SUM_W'(delta_q[PERIOD_W-1:0]);
  always_comb begin
    if (!in_win) begin
      new_period = hit_entry_q.period;
    end else if (hit_entry_q.period == '0) begin
      new_period = delta_q[PERIOD_W-1:0];
    end else begin
      new_period = ewma_sum[PERIOD_W+1:2];
    end
  end

  always_comb begin
    ram_re     = (state_q == S_SCAN) && (cnt_q < CNT_W'(ENTRIES));
    ram_we     = 1'b0;
    ram_waddr  = free_idx_q;
    ram_wentry = '{ca: ca_q, provider: prov_q, service: svc_q, word_high: wh_q,
                   word_low: wl_q, last_change: now_q, period: '0};
    if (state_q == S_WR) begin
      if (hit_q) begin
        ram_we           = chg_q;
        ram_waddr        = hit_idx_q;
        ram_wentry.period = new_period;
      end else begin
        ram_we = 1'b1;
      end
    end
  end

  cpe_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ENTRY_W'(ram_wentry)),
    .re_i   (ram_re),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_OBSERVE: begin
              state_d = (ca_id_i == '0 || service_id_i == '0) ? S_RESP : S_SCAN;
            end
            KIND_QUERY: state_d = S_SCAN;
            KIND_CLEAN: state_d = S_CHECK;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_CHECK: state_d = (diff < clean_interval_q) ? S_RESP : S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (kind_q == KIND_OBSERVE && hit_q) begin
            state_d = S_CALC;
          end else if (kind_q == KIND_OBSERVE && free_q) begin
            state_d = S_WR;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_CALC: state_d = S_WR;
      S_WR:   state_d = S_RESP;
      S_RESP: state_d = out_free ? S_IDLE : S_RESP;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      min_period_q     <= MIN_PERIOD_RST;
      max_period_q     <= MAX_PERIOD_RST;
      stale_age_q      <= STALE_AGE_RST;
      clean_interval_q <= CLEAN_INTERVAL_RST;
      last_clean_q     <= '0;
      valid_q          <= '0;
      cnt_q            <= '0;
      rd_vld_q         <= 1'b0;
      hit_q            <= 1'b0;
      free_q           <= 1'b0;
      rem_q            <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MIN_PERIOD:     min_period_q     <= cfg_data_i[PERIOD_W-1:0];
          REG_MAX_PERIOD:     max_period_q     <= cfg_data_i[PERIOD_W-1:0];
          REG_STALE_AGE:      stale_age_q      <= cfg_data_i[TIME_W-1:0];
          REG_CLEAN_INTERVAL: clean_interval_q <= cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end

      // load a new result, or release the one just taken
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          cnt_q    <= '0;
          rd_vld_q <= 1'b0;
          hit_q    <= 1'b0;
          free_q   <= 1'b0;
          rem_q    <= '0;
        end
        S_CHECK: begin
          if (diff >= clean_interval_q) begin
            last_clean_q <= now_q;
          end
        end
        S_SCAN: begin
          rd_vld_q <= ram_re;
          if (ram_re) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (rd_vld_q) begin
            if (kind_q == KIND_CLEAN) begin
              if (valid_q[rd_idx_q] && diff > stale_age_q) begin
                valid_q[rd_idx_q] <= 1'b0;
                rem_q             <= rem_q + REMOVE_W'(1);
              end
            end else if (valid_q[rd_idx_q]) begin
              if (key_match && !hit_q) begin
                hit_q <= 1'b1;
              end
            end else if (!free_q) begin
              free_q <= 1'b1;
            end
          end
        end
        S_WR: begin
          if (!hit_q) begin
            valid_q[free_idx_q] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        kind_q       <= kind_i;
        now_q        <= now_ms_i;
        ca_q         <= ca_id_i;
        prov_q       <= provider_id_i;
        svc_q        <= service_id_i;
        wh_q         <= word_high_i;
        wl_q         <= word_low_i;
        res_period_q <= '0;
        res_found_q  <= 1'b0;
        res_status_q <= (kind_i == KIND_OBSERVE && (ca_id_i == '0 || service_id_i == '0)) ?
                        ST_ZERO : ST_OK;
      end
      S_CHECK: begin
        if (diff < clean_interval_q) begin
          res_status_q <= ST_SKIP;
        end
      end
      S_SCAN: begin
        rd_idx_q <= cnt_q[IDX_W-1:0];
        if (rd_vld_q && kind_q != KIND_CLEAN) begin
          if (valid_q[rd_idx_q]) begin
            if (key_match && !hit_q) begin
              hit_idx_q   <= rd_idx_q;
              hit_entry_q <= rd_entry;
            end
          end else if (!free_q) begin
            free_idx_q <= rd_idx_q;
          end
        end
        if (scan_done) begin
          if (kind_q == KIND_QUERY && hit_q) begin
            res_found_q  <= 1'b1;
            res_period_q <= hit_entry_q.period;
          end
          if (kind_q == KIND_OBSERVE && !hit_q && !free_q) begin
            res_status_q <= ST_FULL;
          end
        end
      end
      S_CALC: begin
        delta_q <= diff;
        chg_q   <= (hit_entry_q.word_high != wh_q) || (hit_entry_q.word_low != wl_q);
      end
      S_WR: begin
        if (hit_q) begin
          res_found_q  <= 1'b1;
          res_period_q <= chg_q ? new_period : hit_entry_q.period;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_period_q  <= res_period_q;
          out_found_q   <= res_found_q;
          out_status_q  <= res_status_q;
          out_removed_q <= rem_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign period_ms_o     = out_period_q;
  assign found_o         = out_found_q;
  assign status_o        = out_status_q;
  assign removed_count_o = out_removed_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready again right after an input transfer");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("matched entry reported with a non-ok status");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SKIP |-> removed_count_o == '0 && period_ms_o == '0)
    else $error("skipped cleanup reports removals or a period");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_WR && kind_q == KIND_OBSERVE)
    else $error("entry ram written outside the observe write step");

endmodule

/* tb/channel_period_estimator_tb.sv */
`timescale 1ns / 100ps

import cpe_pkg::*;

// shadow of the channel table: works out the answer to every accepted item
class channel_ledger;
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [REMOVE_W-1:0] removed;
  } answer_t;

  bit                  used[ENTRIES_DEF];
  logic [CA_W-1:0]     slot_ca[ENTRIES_DEF];
  logic [PROV_W-1:0]   slot_prov[ENTRIES_DEF];
  logic [SVC_W-1:0]    slot_svc[ENTRIES_DEF];
  logic [HALF_W-1:0]   slot_wh[ENTRIES_DEF];
  logic [HALF_W-1:0]   slot_wl[ENTRIES_DEF];
  logic [TIME_W-1:0]   slot_changed[ENTRIES_DEF];
  logic [PERIOD_W-1:0] slot_period[ENTRIES_DEF];
  logic [TIME_W-1:0]   last_sweep;
  logic [PERIOD_W-1:0] min_p;
  logic [PERIOD_W-1:0] max_p;
  logic [TIME_W-1:0]   stale;
  logic [TIME_W-1:0]   sweep_gap;
  answer_t             answers[$];
  int                  mismatches;

  function new();
    foreach (used[i]) used[i] = 1'b0;
    last_sweep = '0;
    min_p      = MIN_PERIOD_RST;
    max_p      = MAX_PERIOD_RST;
    stale      = STALE_AGE_RST;
    sweep_gap  = CLEAN_INTERVAL_RST;
    mismatches = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_MIN_PERIOD:     min_p = val[PERIOD_W-1:0];
      REG_MAX_PERIOD:     max_p = val[PERIOD_W-1:0];
      REG_STALE_AGE:      stale = val;
      REG_CLEAN_INTERVAL: sweep_gap = val;
      default: ;
    endcase
  endfunction

  function int find(logic [CA_W-1:0] ca, logic [PROV_W-1:0] prov, logic [SVC_W-1:0] svc);
    for (int i = 0; i < ENTRIES_DEF; i++)
      if (used[i] && slot_ca[i] == ca && slot_prov[i] == prov && slot_svc[i] == svc)
        return i;
    return -1;
  endfunction

  function bit changed_at(logic [CA_W-1:0] ca, logic [PROV_W-1:0] prov,
                          logic [SVC_W-1:0] svc, output logic [TIME_W-1:0] t);
    int s;
    s = find(ca, prov, svc);
    t = (s < 0) ? '0 : slot_changed[s];
    return s >= 0;
  endfunction

  function int pending();
    return answers.size();
  endfunction

  function void note_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                          logic [CA_W-1:0] ca, logic [PROV_W-1:0] prov,
                          logic [SVC_W-1:0] svc, logic [HALF_W-1:0] wh,
                          logic [HALF_W-1:0] wl);
    answer_t     a;
    int          s;
    int          f;
    logic [31:0] delta;
    logic [31:0] mix;
    logic [31:0] age;
    a = '0;
    case (kind)
      KIND_OBSERVE: begin
        if (ca == '0 || svc == '0) begin
          a.status = ST_ZERO;
        end else begin
          s = find(ca, prov, svc);
          if (s < 0) begin
            f = -1;
            for (int i = ENTRIES_DEF - 1; i >= 0; i--)
              if (!used[i]) f = i;
            if (f < 0) begin
              a.status = ST_FULL;
            end else begin
              used[f]         = 1'b1;
              slot_ca[f]      = ca;
              slot_prov[f]    = prov;
              slot_svc[f]     = svc;
              slot_wh[f]      = wh;
              slot_wl[f]      = wl;
              slot_changed[f] = now;
              slot_period[f]  = '0;
            end
          end else begin
            a.found = 1'b1;
            if (slot_wh[s] != wh || slot_wl[s] != wl) begin
              delta = now - slot_changed[s];
              if (delta >= 32'(min_p) && delta <= 32'(max_p)) begin
                if (slot_period[s] != '0) begin
                  mix = 32'(slot_period[s]) * 32'd3 + delta;
                  slot_period[s] = mix[PERIOD_W+1:2];
                end else begin
                  slot_period[s] = delta[PERIOD_W-1:0];
                end
              end
              slot_changed[s] = now;
              slot_wh[s]      = wh;
              slot_wl[s]      = wl;
            end
            a.period = slot_period[s];
          end
        end
      end
      KIND_QUERY: begin
        s = find(ca, prov, svc);
        if (s >= 0) begin
          a.found  = 1'b1;
          a.period = slot_period[s];
        end
      end
      KIND_CLEAN: begin
        age = now - last_sweep;
        if (age < sweep_gap) begin
          a.status = ST_SKIP;
        end else begin
          last_sweep = now;
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            age = now - slot_changed[i];
            if (used[i] && age > stale) begin
              used[i]   = 1'b0;
              a.removed = a.removed + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    answers.push_back(a);
  endfunction

  task flag_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_answer(logic [PERIOD_W-1:0] period, logic found,
                    logic [STATUS_W-1:0] status, logic [REMOVE_W-1:0] removed);
    answer_t want;
    if (answers.size() == 0) begin
      flag_mismatch($sformatf("result with nothing pending: period %0d found %0d status %0d",
                              period, found, status));
      return;
    end
    want = answers.pop_front();
    if (period !== want.period)
      flag_mismatch($sformatf("period_ms %0d, wanted %0d", period, want.period));
    if (found !== want.found)
      flag_mismatch($sformatf("found %0d, wanted %0d", found, want.found));
    if (status !== want.status)
      flag_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
    if (removed !== want.removed)
      flag_mismatch($sformatf("removed_count %0d, wanted %0d", removed, want.removed));
  endtask
endclass

module channel_period_estimator_tb;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int KEYS       = 96;
  localparam int STUCK_MAX  = 4000;
  localparam int PHASE_LEN  = 330;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic [CA_W-1:0]      ca_id_i = '0;
  logic [PROV_W-1:0]    provider_id_i = '0;
  logic [SVC_W-1:0]     service_id_i = '0;
  logic [HALF_W-1:0]    word_high_i = '0;
  logic [HALF_W-1:0]    word_low_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PERIOD_W-1:0]  period_ms_o;
  logic                 found_o;
  logic [STATUS_W-1:0]  status_o;
  logic [REMOVE_W-1:0]  removed_count_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  channel_ledger ledger = new();

  bit          calm = 1'b0;
  int          hold_len = 0;
  int          stall_left = 0;
  int          stuck_cycles = 0;
  logic [31:0] t_ms;

  logic [CA_W-1:0]   pool_ca[KEYS];
  logic [PROV_W-1:0] pool_prov[KEYS];
  logic [SVC_W-1:0]  pool_svc[KEYS];
  logic [HALF_W-1:0] pool_wh[KEYS];
  logic [HALF_W-1:0] pool_wl[KEYS];

  channel_period_estimator u_top (.*);

  always #5 clk_i = ~clk_i;

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      out_ready_i <= 1'b0;
      hold_len--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (out_valid_o && out_ready_i)
      ledger.check_answer(period_ms_o, found_o, status_o, removed_count_o);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_MAX) begin
        $display("channel_period_estimator test failed");
        $finish;
      end
    end
  end

  task automatic send(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                      logic [CA_W-1:0] ca, logic [PROV_W-1:0] prov,
                      logic [SVC_W-1:0] svc, logic [HALF_W-1:0] wh,
                      logic [HALF_W-1:0] wl);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i        <= kind;
    now_ms_i      <= now;
    ca_id_i       <= ca;
    provider_id_i <= prov;
    service_id_i  <= svc;
    word_high_i   <= wh;
    word_low_i    <= wl;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_item(kind, now, ca, prov, svc, wh, wl);
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [HALF_W-1:0] fresh_half();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_item();
    int          r;
    int          k;
    int          c;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] now;
    logic [31:0] lastc;
    logic [15:0] ca;
    logic [15:0] svc;
    r   = $urandom_range(0, 99);
    k   = $urandom_range(0, KEYS - 1);
    now = t_ms;
    if (r < 5) begin
      // zero key, ignored by the block
      c   = $urandom_range(0, 2);
      ca  = (c == 1) ? 16'($urandom) : 16'h0;
      svc = (c == 2) ? 16'($urandom) : 16'h0;
      send(KIND_OBSERVE, $urandom, ca, $urandom, svc, fresh_half(), fresh_half());
    end else if (r < 8) begin
      send(KIND_SPARE, $urandom, 16'($urandom), $urandom, 16'($urandom),
           fresh_half(), fresh_half());
    end else if (r < 14) begin
      c = $urandom_range(0, 3);
      case (c)
        0: now = ledger.last_sweep + ledger.sweep_gap - 32'd1;
        1: now = ledger.last_sweep + ledger.sweep_gap;
        2: now = t_ms + $urandom_range(0, 700000);
        default: now = $urandom;
      endcase
      if (c == 1 || c == 2) t_ms = now;
      send(KIND_CLEAN, now, 16'($urandom), $urandom, 16'($urandom),
           fresh_half(), fresh_half());
    end else if (r < 30) begin
      if ($urandom_range(0, 6) == 0)
        send(KIND_QUERY, $urandom, 16'($urandom_range(0, 3)), $urandom,
             16'($urandom_range(0, 3)), fresh_half(), fresh_half());
      else
        send(KIND_QUERY, $urandom, pool_ca[k], pool_prov[k], pool_svc[k],
             fresh_half(), fresh_half());
    end else begin
      if ($urandom_range(0, 9) >= 3) begin
        pool_wh[k] = fresh_half();
        pool_wl[k] = fresh_half();
      end
      if (ledger.changed_at(pool_ca[k], pool_prov[k], pool_svc[k], lastc)) begin
        // aim the change interval around the accepted window
        lo = (ledger.min_p < ledger.max_p) ? 32'(ledger.min_p) : 32'(ledger.max_p);
        hi = (ledger.min_p < ledger.max_p) ? 32'(ledger.max_p) : 32'(ledger.min_p);
        lo = lo / 2;
        hi = hi + hi / 4 + 2;
        c  = $urandom_range(0, 9);
        if (c < 7) now = lastc + $urandom_range(lo, hi);
        else if (c < 8) now = $urandom;
        t_ms = now;
      end
      send(KIND_OBSERVE, now, pool_ca[k], pool_prov[k], pool_svc[k], pool_wh[k], pool_wl[k]);
    end
    t_ms = t_ms + $urandom_range(0, 3000);
  endtask

  initial begin
    int j;
    pool_ca[0] = '1; pool_prov[0] = '1; pool_svc[0] = '1;
    pool_ca[1] = 16'd1; pool_prov[1] = '0; pool_svc[1] = 16'd1;
    for (int i = 2; i < KEYS; i++) begin
      pool_ca[i]   = 16'($urandom_range(1, 16'hFFFF));
      pool_prov[i] = $urandom;
      pool_svc[i]  = 16'($urandom_range(1, 16'hFFFF));
      if (i % 4 == 3) begin
        // near twin of the previous key, one field apart
        pool_ca[i]   = pool_ca[i-1];
        pool_prov[i] = pool_prov[i-1];
        pool_svc[i]  = pool_svc[i-1];
        case (i % 12)
          3: pool_ca[i] = (pool_ca[i] == 16'hFFFF) ? 16'h1 : pool_ca[i] + 16'h1;
          7: pool_prov[i] = ~pool_prov[i];
          default: pool_svc[i] = (pool_svc[i] == 16'hFFFF) ? 16'h1 : pool_svc[i] + 16'h1;
        endcase
      end
    end
    foreach (pool_wh[i]) begin
      pool_wh[i] = fresh_half();
      pool_wl[i] = fresh_half();
    end
    t_ms = $urandom;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part with the reset register values
    send(KIND_OBSERVE, 32'd10, 16'h0, 32'h1234, 16'h1234, '1, '1);
    send(KIND_OBSERVE, 32'd11, 16'h55, 32'h0, 16'h0, '0, '1);
    send(KIND_OBSERVE, 32'd12, 16'h0, '1, 16'h0, '1, '0);
    send(KIND_QUERY, 32'd13, 16'h1, 32'h0, 16'h1, '0, '0);
    send(KIND_QUERY, '1, 16'h0, 32'h0, 16'h0, '0, '0);
    send(KIND_SPARE, '1, '1, '1, '1, '1, '1);
    send(KIND_CLEAN, 32'd0, '0, '0, '0, '0, '0);
    send(KIND_CLEAN, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    send(KIND_OBSERVE, 32'd1_000_000, '1, '1, '1, '1, '1);
    send(KIND_OBSERVE, 32'd1_000_100, '1, '1, '1, '1, '1);
    // interval below the window, then exactly at each edge, then just above
    send(KIND_OBSERVE, 32'd1_000_500, '1, '1, '1, 64'h1, '1);
    send(KIND_OBSERVE, 32'd1_001_500, '1, '1, '1, 64'h2, '1);
    send(KIND_OBSERVE, 32'd1_061_500, '1, '1, '1, 64'h3, '1);
    send(KIND_OBSERVE, 32'd1_121_501, '1, '1, '1, 64'h3, '0);
    send(KIND_QUERY, 32'd0, '1, '1, '1, '0, '0);
    // change interval across the counter wrap
    send(KIND_OBSERVE, 32'hFFFF_FE00, 16'd1, 32'd0, 16'd1, '0, '0);
    send(KIND_OBSERVE, 32'h0000_0200, 16'd1, 32'd0, 16'd1, '1, '1);
    send(KIND_OBSERVE, 32'd1_121_500, 16'd1, 32'd0, 16'd2, 64'h5a5a, 64'ha5a5);
    // one entry sits exactly at the stale age, one just past it, one long past it
    send(KIND_CLEAN, 32'd1_721_501, '0, '0, '0, '0, '0);
    send(KIND_QUERY, 32'd0, 16'd1, 32'd0, 16'd2, '0, '0);
    send(KIND_QUERY, 32'd0, '1, '1, '1, '0, '0);
    send(KIND_OBSERVE, 32'd1_721_600, 16'd7, 32'd7, 16'd7, '0, 64'h7);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_MIN_PERIOD, 32'd0);
          write_reg(REG_MAX_PERIOD, 32'hF_FFFF);
          write_reg(REG_STALE_AGE, 32'hFFFF_FFFF);
          write_reg(REG_CLEAN_INTERVAL, 32'd0);
        end
        1: begin
          // min above max: no interval is ever accepted
          write_reg(REG_MIN_PERIOD, 32'hF_FFFF);
          write_reg(REG_MAX_PERIOD, 32'd0);
          write_reg(REG_STALE_AGE, 32'd0);
          write_reg(REG_CLEAN_INTERVAL, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(REG_MIN_PERIOD, 32'(MIN_PERIOD_RST));
          write_reg(REG_MAX_PERIOD, 32'(MAX_PERIOD_RST));
          write_reg(REG_STALE_AGE, STALE_AGE_RST);
          write_reg(REG_CLEAN_INTERVAL, CLEAN_INTERVAL_RST);
        end
        default: begin
          j = $urandom_range(0, 3000);
          write_reg(REG_MIN_PERIOD, 32'(j));
          write_reg(REG_MAX_PERIOD, 32'(j + $urandom_range(0, 80000)));
          write_reg(REG_STALE_AGE, $urandom_range(10000, 400000));
          write_reg(REG_CLEAN_INTERVAL, $urandom_range(0, 100000));
        end
      endcase
      if (ph == 1) hold_len = 400;
      // more keys than slots, so the table overflows
      if (ph == 0 || ph == 2)
        for (int k = 0; k < KEYS; k++)
          send(KIND_OBSERVE, t_ms, pool_ca[k], pool_prov[k], pool_svc[k],
               pool_wh[k], pool_wl[k]);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 4 && i == 30) calm = 1'b1;
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (ledger.mismatches == 0)
      $display("channel_period_estimator test passed");
    else
      $display("channel_period_estimator test failed");
    $finish;
  end

endmodule

/* sim.f */
src/cpe_pkg.sv
src/cpe_ram.sv
src/channel_period_estimator.sv
tb/channel_period_estimator_tb.sv
